[rtl/ugri_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ugri_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POINT = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STORED = 2'd0,
        KIND_CAND   = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_FULL   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAP,
        ST_DIV,
        ST_RD,
        ST_WAIT,
        ST_MOD,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

[rtl/ugri_cell_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Computes min(res-1, floor(d*res/s)) for a non-negative offset d by
// restoring division, one quotient bit per cycle.
module ugri_cell_div #(
    parameter int GRID_RES = 8,
    parameter int CW = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          neg,
    input  wire logic [16:0]   offset,
    input  wire logic [14:0]   size,
    output logic               done,
    output logic [CW-1:0]      cell_idx
);
    localparam int NW = 17 + $clog2(GRID_RES + 1);
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [15:0]   rem_reg, rem_next;
    logic [14:0]   div_reg, div_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg, neg_next;
    logic [16:0]   trial;

    // One restoring step per cycle.
    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, num_reg[NW-1]};
        if (start)
        begin
            num_next  = NW'(offset) * NW'(GRID_RES);
            quo_next  = '0;
            rem_next  = '0;
            div_next  = (size == '0) ? 15'd1 : size;
            cnt_next  = SW'(NW);
            busy_next = 1'b1;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (trial >= {2'b00, div_reg})
            begin
                rem_next = 16'(trial - {2'b00, div_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done = !busy_reg;

    // Clamp to the last cell and force zero below the origin.
    always_comb
    begin
        if (neg_reg)
            cell_idx = '0;
        else if (quo_reg > NW'(GRID_RES - 1))
            cell_idx = CW'(GRID_RES - 1);
        else
            cell_idx = quo_reg[CW-1:0];
    end
endmodule
`default_nettype wire

[rtl/ugri_cell_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// Cell bitmap memory: one write port, one registered read port.
module ugri_cell_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/uniform_grid_rect_index.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow: a point without last_point only widens the open box. A closing
// point (table not full) or a query (table not empty) maps each box edge
// to a cell by serial division, then reads each covered cell and sets the
// shape bit or gathers the bits; a query then emits one candidate per cycle
// while the output is not stalled. One item at a time, set by the serial
// divider and the single bitmap port; a clear or reset zeroes every cell.
module uniform_grid_rect_index #(
    parameter int GRID_RES = 8,
    parameter int MAX_SHAPES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           op,
    input  wire logic signed [15:0]   point_x,
    input  wire logic signed [15:0]   point_y,
    input  wire logic                 last_point,
    input  wire logic signed [15:0]   query_left,
    input  wire logic signed [15:0]   query_top,
    input  wire logic signed [15:0]   query_right,
    input  wire logic signed [15:0]   query_bottom,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                kind,
    output logic [5:0]                shape_index,
    output logic                      last
);
    import ugri_pkg::*;

    localparam int CW    = $clog2(GRID_RES);
    localparam int CELLS = GRID_RES * GRID_RES;
    localparam int AW    = 2 * CW;
    localparam int SCW   = $clog2(MAX_SHAPES + 1);

    // Configuration registers.
    logic signed [15:0] left_reg, top_reg;
    logic [14:0]        width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= 15'd800;
            height_reg <= 15'd800;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LEFT:   left_reg   <= cfg_data;
                CFG_TOP:    top_reg    <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[14:0];
                CFG_HEIGHT: height_reg <= cfg_data[14:0];
                default:    ;
            endcase
        end
    end

    // Control and datapath registers.
    state_t state_reg, state_next;
    logic [SCW-1:0] count_reg, count_next;
    logic in_shape_reg, in_shape_next;
    logic signed [15:0] bx0_reg, bx0_next, bx1_reg, bx1_next;
    logic signed [15:0] by0_reg, by0_next, by1_reg, by1_next;
    logic signed [15:0] e_reg [4];
    logic signed [15:0] e_next [4];
    logic is_query_reg, is_query_next;
    logic [1:0] map_reg, map_next;
    logic [CW-1:0] lim_reg [4];
    logic [CW-1:0] lim_next [4];
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [63:0] acc_reg, acc_next;
    logic [5:0] bit_reg, bit_next;
    logic ov_reg, ov_next;
    logic [1:0] kind_reg, kind_next;
    logic [5:0] idx_reg, idx_next;
    logic last_reg, last_next;

    // Divider hookup: one axis edge at a time.
    logic div_start, div_done;
    logic [CW-1:0] div_cell;
    logic signed [16:0] diff;
    logic signed [15:0] org;
    logic [14:0] dsize;
    logic [AW-1:0] mem_addr, mem_waddr;
    logic mem_we;
    logic [63:0] mem_wdata, mem_rdata;
    logic accept, out_free;

    assign org   = map_reg[1] ? top_reg : left_reg;
    assign dsize = map_reg[1] ? height_reg : width_reg;
    assign diff  = 17'(e_reg[map_reg]) - 17'(org);

    ugri_cell_div #(.GRID_RES(GRID_RES), .CW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .neg(diff[16]),
        .offset(diff[16] ? 17'd0 : 17'(diff)), .size(dsize),
        .done(div_done), .cell_idx(div_cell)
    );

    ugri_cell_mem #(.DEPTH(CELLS), .AW(AW), .DW(64)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_addr), .rdata(mem_rdata)
    );

    assign mem_addr = AW'(cy_reg) * AW'(GRID_RES) + AW'(cx_reg);
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign accept   = in_valid && !in_stall;

    // Lowest set bit of the candidate word.
    logic [5:0] low_bit;
    always_comb
    begin
        low_bit = '0;
        for (int i = 63; i >= 0; i--)
            if (acc_reg[i])
                low_bit = 6'(i);
    end
    logic [63:0] acc_rest;
    assign acc_rest = acc_reg & ~(64'd1 << low_bit);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (op_t'(op) == OP_CLEAR)
                        state_next = ST_CLEAR;
                    else if (op_t'(op) == OP_QUERY)
                        state_next = (count_reg == '0) ? ST_EMIT : ST_MAP;
                    else if (op_t'(op) == OP_POINT && last_point)
                        state_next = (count_reg >= SCW'(MAX_SHAPES)) ? ST_EMIT : ST_MAP;
                end
            ST_CLEAR: if (clr_reg == AW'(CELLS - 1)) state_next = ST_IDLE;
            ST_MAP:   state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = (map_reg == 2'd3) ? ST_RD : ST_MAP;
            ST_RD:    state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_MOD;
            ST_MOD:
                if (cx_reg == lim_reg[1] && cy_reg == lim_reg[3]) state_next = ST_SCAN;
                else if (cx_reg == lim_reg[1] && cy_reg >= lim_reg[3]) state_next = ST_SCAN;
                else state_next = ST_RD;
            ST_SCAN:  state_next = ST_EMIT;
            ST_EMIT:
                if (out_free && (!is_query_reg || acc_reg == '0 || acc_rest == '0))
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        count_next    = count_reg;
        in_shape_next = in_shape_reg;
        bx0_next = bx0_reg; bx1_next = bx1_reg;
        by0_next = by0_reg; by1_next = by1_reg;
        e_next        = e_reg;
        is_query_next = is_query_reg;
        map_next      = map_reg;
        lim_next      = lim_reg;
        cx_next = cx_reg; cy_next = cy_reg;
        clr_next      = clr_reg;
        acc_next      = acc_reg;
        bit_next      = bit_reg;
        ov_next       = ov_reg && out_stall;
        kind_next = kind_reg; idx_next = idx_reg; last_next = last_reg;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = mem_addr;
        mem_wdata = mem_rdata | (64'd1 << bit_reg);
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    map_next = 2'd0;
                    acc_next = '0;
                    bit_next = 6'(count_reg);
                    case (op_t'(op))
                        OP_CLEAR:
                        begin
                            clr_next      = '0;
                            count_next    = '0;
                            in_shape_next = 1'b0;
                        end
                        OP_POINT:
                        begin
                            is_query_next = 1'b0;
                            begin : box
                                logic signed [15:0] n0, n1, m0, m1;
                                n0 = point_x; n1 = point_x; m0 = point_y; m1 = point_y;
                                if (in_shape_reg)
                                begin
                                    n0 = (point_x < bx0_reg) ? point_x : bx0_reg;
                                    n1 = (point_x > bx1_reg) ? point_x : bx1_reg;
                                    m0 = (point_y < by0_reg) ? point_y : by0_reg;
                                    m1 = (point_y > by1_reg) ? point_y : by1_reg;
                                end
                                bx0_next = n0; bx1_next = n1; by0_next = m0; by1_next = m1;
                                e_next[0] = n0; e_next[1] = n1;
                                e_next[2] = m0; e_next[3] = m1;
                            end
                            in_shape_next = !last_point;
                            kind_next = KIND_FULL; idx_next = '0; last_next = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            is_query_next = 1'b1;
                            e_next[0] = query_left;  e_next[1] = query_right;
                            e_next[2] = query_top;   e_next[3] = query_bottom;
                        end
                        default: ;
                    endcase
                end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_MAP: div_start = 1'b1;
            ST_DIV:
                if (div_done)
                begin
                    lim_next[map_reg] = div_cell;
                    map_next = map_reg + 1'b1;
                    cx_next = (map_reg == 2'd3) ? lim_reg[0] : cx_reg;
                    cy_next = lim_reg[2];
                    // Empty range: start at the end corner, so the walk stops there and writes nothing.
                    if (map_reg == 2'd3 && (div_cell < lim_reg[2] || lim_reg[1] < lim_reg[0]))
                    begin
                        cx_next = lim_reg[1];
                        cy_next = div_cell;
                    end
                end
            ST_MOD:
            begin
                if ((lim_reg[1] >= lim_reg[0]) && (lim_reg[3] >= lim_reg[2]))
                begin
                    if (is_query_reg)
                        acc_next = acc_reg | mem_rdata;
                    else
                        mem_we = 1'b1;
                end
                if (cx_reg == lim_reg[1])
                begin
                    cx_next = lim_reg[0];
                    cy_next = cy_reg + 1'b1;
                end
                else
                    cx_next = cx_reg + 1'b1;
            end
            ST_SCAN:
                if (!is_query_reg)
                begin
                    kind_next  = KIND_STORED;
                    idx_next   = bit_reg;
                    last_next  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            ST_EMIT:
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (is_query_reg)
                    begin
                        if (acc_reg == '0)
                        begin
                            kind_next = KIND_EMPTY; idx_next = '0; last_next = 1'b1;
                        end
                        else
                        begin
                            kind_next = KIND_CAND; idx_next = low_bit;
                            last_next = (acc_rest == '0);
                            acc_next  = acc_rest;
                        end
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            in_shape_reg <= 1'b0;
            ov_reg       <= 1'b0;
            map_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            in_shape_reg <= in_shape_next;
            ov_reg       <= ov_next;
            map_reg      <= map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx0_reg <= bx0_next; bx1_reg <= bx1_next;
        by0_reg <= by0_next; by1_reg <= by1_next;
        e_reg <= e_next;
        is_query_reg <= is_query_next;
        lim_reg <= lim_next;
        cx_reg <= cx_next; cy_reg <= cy_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
        kind_reg <= kind_next; idx_reg <= idx_next; last_reg <= last_next;
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign shape_index = idx_reg;
    assign last        = last_reg;
endmodule
`default_nettype wire

[sim/tb_uniform_grid_rect_index.sv]
`timescale 1ns / 1ps
module tb_uniform_grid_rect_index;
    import ugri_pkg::*;

    localparam int GRID = 8;
    localparam int SHAPES_MAX = 64;
    localparam int IDLE_GAP = 200;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] shape_index;
        logic       last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] op = '0;
    logic signed [15:0] point_x = '0, point_y = '0;
    logic last_point = 1'b0;
    logic signed [15:0] query_left = '0, query_top = '0, query_right = '0, query_bottom = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] kind;
    logic [5:0] shape_index;
    logic last;

    // Predictor state.
    logic [63:0] grid_bits [GRID*GRID];
    int unsigned stored_count;
    int box_lx, box_hx, box_ly, box_hy;
    bit shape_open;
    int org_x, org_y;
    int unsigned span_x, span_y;

    result_t expected_results[$];
    int mismatch_count = 0;
    longint cycle_count = 0;

    uniform_grid_rect_index i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .point_x(point_x), .point_y(point_y), .last_point(last_point),
        .query_left(query_left), .query_top(query_top),
        .query_right(query_right), .query_bottom(query_bottom),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .shape_index(shape_index), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // A 16-bit port value seen as a signed number.
    function automatic int s16(int v);
        return int'($signed(v[15:0]));
    endfunction

    // Cell along one axis, clamped to the grid.
    function automatic int axis_cell(int coord, int origin, int unsigned size);
        longint d;
        longint s;
        longint c;
        d = longint'(coord) - longint'(origin);
        s = (size == 0) ? 1 : longint'(size);
        if (d < 0)
            return 0;
        c = (d * GRID) / s;
        if (c > GRID - 1)
            c = GRID - 1;
        return int'(c);
    endfunction

    function automatic void push_result(kind_t k, int idx, bit fin);
        result_t r;
        r.kind = k;
        r.shape_index = idx[5:0];
        r.last = fin;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Works out the results of one accepted item.
    function automatic void predict_index(logic [1:0] o, int px, int py, bit lp,
                                          int ql, int qt, int qr, int qb);
        int x0, x1, y0, y1;
        logic [63:0] hits;
        px = s16(px); py = s16(py);
        ql = s16(ql); qt = s16(qt); qr = s16(qr); qb = s16(qb);
        if (o == OP_CLEAR)
        begin
            foreach (grid_bits[i])
                grid_bits[i] = '0;
            stored_count = 0;
            shape_open = 0;
        end
        else if (o == OP_POINT)
        begin
            if (!shape_open)
            begin
                box_lx = px; box_hx = px; box_ly = py; box_hy = py;
                shape_open = 1;
            end
            else
            begin
                if (px < box_lx) box_lx = px;
                if (px > box_hx) box_hx = px;
                if (py < box_ly) box_ly = py;
                if (py > box_hy) box_hy = py;
            end
            if (lp)
            begin
                shape_open = 0;
                if (stored_count >= SHAPES_MAX)
                    push_result(KIND_FULL, 0, 1);
                else
                begin
                    x0 = axis_cell(box_lx, org_x, span_x);
                    x1 = axis_cell(box_hx, org_x, span_x);
                    y0 = axis_cell(box_ly, org_y, span_y);
                    y1 = axis_cell(box_hy, org_y, span_y);
                    for (int y = y0; y <= y1; y++)
                        for (int x = x0; x <= x1; x++)
                            grid_bits[y*GRID + x][stored_count] = 1'b1;
                    push_result(KIND_STORED, stored_count, 1);
                    stored_count++;
                end
            end
        end
        else if (o == OP_QUERY)
        begin
            hits = '0;
            if (stored_count != 0)
            begin
                x0 = axis_cell(ql, org_x, span_x);
                x1 = axis_cell(qr, org_x, span_x);
                y0 = axis_cell(qt, org_y, span_y);
                y1 = axis_cell(qb, org_y, span_y);
                for (int y = y0; y <= y1; y++)
                    for (int x = x0; x <= x1; x++)
                        hits |= grid_bits[y*GRID + x];
            end
            if (hits == 0)
                push_result(KIND_EMPTY, 0, 1);
            else
                for (int i = 0; i < SHAPES_MAX; i++)
                    if (hits[i])
                    begin
                        hits[i] = 1'b0;
                        push_result(KIND_CAND, i, hits == 0);
                    end
        end
    endfunction

    // Result checker with a randomly stalling receiver.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result kind=%0d index=%0d last=%0d",
                             kind, shape_index, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.kind !== kind || want.shape_index !== shape_index
                    || want.last !== last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind=%0d index=%0d last=%0d, got %0d %0d %0d",
                                 want.kind, want.shape_index, want.last,
                                 kind, shape_index, last);
                end
            end
        end
    end

    // Stall pattern: a random count of stalled cycles between accepted results.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Sends one item after a random gap and predicts its results.
    // Valid stays high after acceptance when the next item follows at once.
    task automatic send_item(logic [1:0] o, int px, int py, bit lp,
                             int ql, int qt, int qr, int qb, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        point_x <= px; point_y <= py; last_point <= lp;
        query_left <= ql; query_top <= qt; query_right <= qr; query_bottom <= qb;
        do
            @(posedge clk);
        while (in_stall);
        predict_index(o, px, py, lp, ql, qt, qr, qb);
    endtask

    task automatic send_point(int px, int py, bit lp);
        send_item(OP_POINT, px, py, lp, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_query(int ql, int qt, int qr, int qb);
        send_item(OP_QUERY, $urandom, $urandom, $urandom, ql, qt, qr, qb);
    endtask

    task automatic send_clear();
        send_item(OP_CLEAR, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // Waits until every expected result is in, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_canvas(int left, int top, int unsigned w, int unsigned h);
        int vals[4];
        vals = '{left, top, w, h};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i][15:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        org_x = int'($signed(left[15:0]));
        org_y = int'($signed(top[15:0]));
        span_x = w & 32'h7fff;
        span_y = h & 32'h7fff;
    endtask

    // Corners, edge clamping, ignored op, empty and inverted queries.
    task automatic test_directed();
        send_query(0, 0, 799, 799);
        send_point(-32768, -32768, 1);
        send_point(32767, 32767, 1);
        send_point(100, 100, 0);
        send_point(50, 700, 0);
        send_point(300, 200, 1);
        send_query(-32768, -32768, 32767, 32767);
        send_query(700, 700, 100, 100);
        send_query(400, 10, 799, 90);
        send_item(OP_NONE, 16'h5555, 16'haaaa, 1, 1, 2, 3, 4);
        send_point(0, 0, 0);
        send_query(0, 0, 0, 0);
        send_point(799, 799, 1);
        send_query(799, 799, 799, 799);
        send_clear();
        send_query(-32768, -32768, 32767, 32767);
        send_point(10, 10, 0);
        send_clear();
        send_point(20, 20, 1);
        send_query(0, 0, 99, 99);
    endtask

    // Fills the table and goes two past it.
    task automatic test_table_full();
        send_clear();
        for (int i = 0; i < SHAPES_MAX + 2; i++)
            send_point($urandom_range(0, 800), $urandom_range(0, 800), 1);
        send_query(0, 0, 799, 799);
        send_clear();
    endtask

    // Random shapes, queries, clears and ignored ops; mostly in the canvas, some anywhere.
    task automatic test_random(int items);
        int pts;
        for (int n = 0; n < items; )
        begin
            case ($urandom_range(0, 9))
                0: begin send_clear(); n++; end
                1: begin send_item(OP_NONE, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom); end
                2, 3, 4: begin
                    if (n % 37 == 5)
                        drain();
                    send_query(org_x + $urandom_range(0, span_x) - 20,
                               org_y + $urandom_range(0, span_y) - 20,
                               org_x + $urandom_range(0, span_x) + 20,
                               org_y + $urandom_range(0, span_y) + 20);
                    n++;
                end
                5: begin send_query($urandom, $urandom, $urandom, $urandom); n++; end
                default: begin
                    pts = $urandom_range(1, 4);
                    for (int p = 0; p < pts; p++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_point($urandom, $urandom, p == pts - 1);
                        else
                            send_point(org_x + $urandom_range(0, span_x),
                                       org_y + $urandom_range(0, span_y), p == pts - 1);
                        n++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        foreach (grid_bits[i])
            grid_bits[i] = '0;
        stored_count = 0;
        shape_open = 0;
        box_lx = 0; box_hx = 0; box_ly = 0; box_hy = 0;
        org_x = 0; org_y = 0; span_x = 800; span_y = 800;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (GRID*GRID + 4) @(posedge clk);

        test_directed();
        test_table_full();
        write_canvas(-32768, -32768, 32767, 32767);
        test_random(60);
        write_canvas(32767, 32767, 1, 1);
        send_point(32767, 32767, 1);
        send_point(-32768, 0, 1);
        send_query(32767, 32767, 32767, 32767);
        send_query(-32768, -32768, 32766, 32766);
        write_canvas(100, -50, 0, 0);
        send_point(100, -50, 1);
        send_query(100, -50, 101, -49);
        write_canvas(-100, 200, 64, 8);
        test_random(100);
        write_canvas(0, 0, 800, 800);
        test_random(110);
        drain();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
